@@ sv/hamming_encode_and_correct_core_assert.svh @@
// assertion macros for the hamming codec, empty when SYNTH is defined
`ifndef HAMMING_ENCODE_AND_CORRECT_CORE_ASSERT_SVH
`define HAMMING_ENCODE_AND_CORRECT_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define HEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hec assertion failed");
// next-cycle implication, checked out of reset
`define HEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hec assertion failed");
`else
`define HEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/hec_pkg.sv @@
// shared types, constants and bit functions of the hamming codec
`timescale 1ns / 1ps
`default_nettype none

package hec_pkg;

  localparam int MaxCodeBits = 63;
  localparam int PosW        = 6;
  localparam int CfgW        = 6;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_CHECK  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BEYOND    = 2'd2
  } status_e;

  // derived code geometry, static between configuration writes
  typedef struct packed {
    logic [PosW-1:0]        n;
    logic [MaxCodeBits-1:0] mask;
  } cfg_t;

  // after placement: word masked to the code length
  typedef struct packed {
    req_e                   req;
    logic [MaxCodeBits-1:0] word;
  } s1_t;

  // after parity trees
  typedef struct packed {
    req_e                   req;
    logic [MaxCodeBits-1:0] word;
    logic [PosW-1:0]        synd;
  } s2_t;

  // result transfer
  typedef struct packed {
    logic [MaxCodeBits-1:0] word;
    logic [PosW-1:0]        err;
    status_e                status;
  } s3_t;

  // smallest p with 2^p >= d + p + 1; 7 when no p up to 6 fits
  function automatic logic [2:0] hec_parity_count(input logic [CfgW-1:0] d);
    logic [2:0] p;
    p = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if ((8'd1 << i) >= (8'(d) + 8'(i) + 8'd1)) p = 3'(i);
    end
    return p;
  endfunction

  // largest data length whose code still fits
  function automatic int hec_max_data();
    int best;
    best = 1;
    for (int d = 1; d < (1 << CfgW); d++) begin
      if (d + int'(hec_parity_count(CfgW'(d))) <= MaxCodeBits) best = d;
    end
    return best;
  endfunction

  localparam int MaxDataBits   = hec_max_data();
  localparam int ResetDataBits = 4;

  // code length for a raw data length, with zero and overlong values clamped
  function automatic logic [PosW-1:0] hec_code_bits(input logic [CfgW-1:0] d_raw);
    logic [CfgW-1:0] d;
    d = d_raw;
    if (d == '0) d = CfgW'(1);
    else if (d > CfgW'(MaxDataBits)) d = CfgW'(MaxDataBits);
    return PosW'(d + CfgW'(hec_parity_count(d)));
  endfunction

  // ones below position n
  function automatic logic [MaxCodeBits-1:0] hec_low_mask(input logic [PosW-1:0] n);
    logic [MaxCodeBits-1:0] m;
    for (int k = 0; k < MaxCodeBits; k++) m[k] = (PosW'(k) < n);
    return m;
  endfunction

  localparam logic [PosW-1:0]        ResetCodeBits = hec_code_bits(CfgW'(ResetDataBits));
  localparam logic [MaxCodeBits-1:0] ResetMask     = hec_low_mask(ResetCodeBits);

  // data bit j goes to the j-th position that is not a power of two
  function automatic logic [MaxCodeBits-1:0] hec_scatter(
    input logic [MaxCodeBits-1:0] data
  );
    logic [MaxCodeBits-1:0] w;
    int j;
    w = '0;
    j = 0;
    for (int k = 0; k < MaxCodeBits; k++) begin
      if ((((k + 1) & k)) != 0) begin
        w[k] = data[j];
        j++;
      end
    end
    return w;
  endfunction

  // xor of the 1-based positions of all set bits
  function automatic logic [PosW-1:0] hec_syndrome(input logic [MaxCodeBits-1:0] w);
    logic [PosW-1:0] s;
    s = '0;
    for (int k = 0; k < MaxCodeBits; k++) begin
      if (w[k]) s = s ^ PosW'(k + 1);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/hec_cfg.sv @@
// data length register, kept as code length and position mask
`timescale 1ns / 1ps
`default_nettype none

module hec_cfg
  import hec_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output cfg_t                 cfg_o
);

  logic [PosW-1:0]        n_q, n_d;
  logic [MaxCodeBits-1:0] mask_q, mask_d;

  // geometry follows from the written length at write time
  always_comb begin
    n_d    = hec_code_bits(cfg_wdata_i);
    mask_d = hec_low_mask(n_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= ResetCodeBits;
      mask_q <= ResetMask;
    end else if (cfg_we_i) begin
      n_q    <= n_d;
      mask_q <= mask_d;
    end
  end

  assign cfg_o.n    = n_q;
  assign cfg_o.mask = mask_q;

endmodule

`default_nettype wire

@@ sv/hec_place.sv @@
// first stage: data placement for encode, length mask for both requests
`timescale 1ns / 1ps
`default_nettype none

module hec_place
  import hec_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic                   req_type_i,
  input  wire logic [MaxCodeBits-1:0] payload_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output s1_t                         data_o
);

  logic valid_q;
  s1_t  data_q, data_d;

  // stage moves when empty or when the next one takes its item
  assign ready_o = !valid_q || ready_i;

  // placed positions beyond the length carry only ignored data bits
  always_comb begin
    data_d.req = req_e'(req_type_i);
    if (data_d.req == REQ_ENCODE) data_d.word = hec_scatter(payload_i) & cfg_i.mask;
    else data_d.word = payload_i & cfg_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ sv/hec_synd.sv @@
// second stage: six parity trees forming the syndrome
`timescale 1ns / 1ps
`default_nettype none

module hec_synd
  import hec_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s1_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output s2_t       data_o
);

  logic valid_q;
  s2_t  data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  // parity of each position bit over the masked word
  always_comb begin
    data_d.req  = data_i.req;
    data_d.word = data_i.word;
    data_d.synd = hec_syndrome(data_i.word);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ sv/hec_fix.sv @@
// third stage: parity insertion or single-bit correction into the output register
`timescale 1ns / 1ps
`default_nettype none
`include "hamming_encode_and_correct_core_assert.svh"

module hec_fix
  import hec_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s2_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output s3_t       data_o
);

  logic                   valid_q;
  s3_t                    data_q, data_d;
  logic [MaxCodeBits-1:0] word;

  assign ready_o = !valid_q || ready_i;

  // encode sets parity from the syndrome; check flips the flagged bit within length
  always_comb begin
    word          = data_i.word;
    data_d.err    = '0;
    data_d.status = ST_OK;
    if (data_i.req == REQ_ENCODE) begin
      for (int i = 0; i < PosW; i++) begin
        if (data_i.synd[i]) word[PosW'((1 << i) - 1)] = 1'b1;
      end
    end else begin
      data_d.err = data_i.synd;
      if (data_i.synd == '0) begin
        data_d.status = ST_OK;
      end else if (data_i.synd <= cfg_i.n) begin
        word[PosW'(data_i.synd - PosW'(1))] = ~word[PosW'(data_i.synd - PosW'(1))];
        data_d.status = ST_CORRECTED;
      end else begin
        data_d.status = ST_BEYOND;
      end
    end
    data_d.word = word & cfg_i.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // every encoded or repaired word is a clean codeword
  `HEC_ASSERT_IMP(a_clean_word, clk_i, rst_ni,
                  valid_q && (data_q.status != ST_BEYOND),
                  hec_syndrome(data_q.word) == '0)
  // an out-of-range syndrome really lies past the code length
  `HEC_ASSERT_IMP(a_beyond_len, clk_i, rst_ni,
                  valid_q && (data_q.status == ST_BEYOND),
                  data_q.err > cfg_i.n)
  // no bits above the code length leave the block
  `HEC_ASSERT_IMP(a_masked_out, clk_i, rst_ni, valid_q, (data_q.word & ~cfg_i.mask) == '0)

endmodule

`default_nettype wire

@@ sv/hamming_encode_and_correct_core.sv @@
// hamming single-error-correcting codec with run-time data length, top level
// each item passes the placement, syndrome and output registers in turn
// throughput: one item per cycle; three register stages, an output stall reaches the input
// only once every stage holds an item
// reset: asynchronous active low, empties the pipeline and sets data length to four
`timescale 1ns / 1ps
`default_nettype none
`include "hamming_encode_and_correct_core_assert.svh"

module hamming_encode_and_correct_core
  import hec_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgW-1:0]        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   req_type_i,
  input  wire logic [MaxCodeBits-1:0] payload_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [MaxCodeBits-1:0]      codeword_o,
  output logic [PosW-1:0]             error_position_o,
  output logic [1:0]                  status_o
);

  cfg_t cfg;
  logic s1_ready, s1_valid, s2_ready, s2_valid, s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;

  // length register
  hec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // placement stage
  hec_place u_place (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (in_valid_i),
    .ready_o    (s1_ready),
    .req_type_i (req_type_i),
    .payload_i  (payload_i),
    .valid_o    (s1_valid),
    .ready_i    (s2_ready),
    .data_o     (s1_data)
  );

  // syndrome stage
  hec_synd u_synd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  // correction stage and output register
  hec_fix u_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (s3_data)
  );

  assign in_stall_o       = !s1_ready;
  assign codeword_o       = s3_data.word;
  assign error_position_o = s3_data.err;
  assign status_o         = s3_data.status;

  // an empty pipeline with no incoming transfer cannot produce a result
  `HEC_ASSERT_NXT(a_no_invent, clk_i, rst_ni,
                  !in_valid_i && !s1_valid && !s2_valid && !out_valid_o,
                  !out_valid_o)
  // results with ok status, encode results among them, report no error position
  `HEC_ASSERT_IMP(a_ok_no_pos, clk_i, rst_ni,
                  out_valid_o && (status_o == ST_OK),
                  error_position_o == '0)
  // a stalled result stays offered and unchanged
  `HEC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(codeword_o) && $stable(status_o))

endmodule

`default_nettype wire
